>>> sv/binary_max_heap_core_macros.svh
// Assertion macros for the heap core.
`ifndef BINARY_MAX_HEAP_CORE_MACROS_SVH
`define BINARY_MAX_HEAP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BMH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BMH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define BMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/bmh_pkg.sv
// Types and codes shared by the heap core and its storage.
package bmh_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_REPLACE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       entry_count;
        logic [1:0]               status;
    } t_result;

endpackage

>>> sv/binary_max_heap_core.sv
// Binary max-heap priority queue: control sequencer around the heap storage.
//
// Request channel: drive i_request (op, value) and raise start; the request
// is taken at a clock edge where start is high and busy is low. busy stays
// high while the sift runs.
// Result channel: o_strobe is high for exactly one cycle with o_result
// (top value, entry count, status); the receiver must take it then.
// Result timing: a refused request, or an insert into an empty heap, gives
// its result in the cycle after acceptance. Otherwise the walk makes one
// registered memory read per heap level, plus a root write in S_UP_FIN when
// an inserted value climbs to the root, before the result shows.
// busy falls in the cycle the result shows, so the next request can be taken
// then; no new request is taken while a walk runs.
// Reset clears the entry count and the sequencer; the storage is not
// cleared, since only entries below the count are ever used.
`include "binary_max_heap_core_macros.svh"
module binary_max_heap_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bmh_pkg::t_request i_request,
    output logic              busy,
    output logic              o_strobe,
    output bmh_pkg::t_result  o_result
);
    import bmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UP,
        S_UP_FIN,
        S_DN
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_idx, n_idx;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic signed [DATA_W-1:0] r_top;
    logic                     r_strobe, n_strobe;
    t_result                  r_result, n_result;
    logic [1:0]               n_status;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic [AW-1:0]            mem_raddr_a;
    logic [AW-1:0]            mem_raddr_b;
    logic [DATA_W-1:0]        mem_rdata_a;
    logic [DATA_W-1:0]        mem_rdata_b;

    logic signed [DATA_W-1:0] rd_a;
    logic signed [DATA_W-1:0] rd_b;
    logic [CW:0]              count_up;
    logic [CW:0]              child_l;
    logic [CW:0]              child_r;
    logic [CW:0]              pick_idx;
    logic [CW+1:0]            pick_child;
    logic [CW-1:0]            parent;
    logic                     has_l;
    logic                     has_r;
    logic                     pick_r;
    logic signed [DATA_W-1:0] pick_val;
    logic signed [DATA_W-1:0] fin_top;

    bmh_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    assign rd_a = mem_rdata_a;
    assign rd_b = mem_rdata_b;

    // Walk geometry for the current node.
    assign count_up   = {1'b0, r_count} + 1'b1;
    assign parent     = r_idx >> 1;
    assign child_l    = {r_idx, 1'b0};
    assign child_r    = {r_idx, 1'b1};
    assign has_l      = child_l <= {1'b0, r_count};
    assign has_r      = child_r <= {1'b0, r_count};
    // Take the right child on a tie.
    assign pick_r     = has_r && !(rd_a > rd_b);
    assign pick_val   = pick_r ? rd_b : rd_a;
    assign pick_idx   = pick_r ? child_r : child_l;
    assign pick_child = {pick_idx, 1'b0};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_val       = r_val;
        n_strobe    = 1'b0;
        n_status    = ST_OK;
        mem_we      = 1'b0;
        mem_waddr   = AW'(r_idx - 1'b1);
        mem_wdata   = r_val;
        mem_raddr_a = '0;
        mem_raddr_b = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val = i_request.value;
                    if (i_request.op == OP_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_strobe = 1'b1;
                            n_status = ST_FULL;
                        end else if (r_count == '0) begin
                            n_count   = CW'(count_up);
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = i_request.value;
                            n_strobe  = 1'b1;
                        end else begin
                            n_count     = CW'(count_up);
                            n_idx       = CW'(count_up);
                            mem_raddr_a = AW'((count_up >> 1) - 1'b1);
                            n_state     = S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_strobe = 1'b1;
                            n_status = ST_EMPTY;
                        end else begin
                            n_idx       = CW'(1);
                            mem_raddr_a = AW'(1);
                            mem_raddr_b = AW'(2);
                            n_state     = S_DN;
                        end
                    end
                end
            end
            S_UP: begin
                mem_we = 1'b1;
                if (r_val > rd_a) begin
                    // Pull the parent down into the hole and climb.
                    mem_wdata = rd_a;
                    n_idx     = parent;
                    if (parent == CW'(1)) begin
                        n_state = S_UP_FIN;
                    end else begin
                        mem_raddr_a = AW'((parent >> 1) - 1'b1);
                    end
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_UP_FIN: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
            end
            S_DN: begin
                mem_we = 1'b1;
                if (has_l && (r_val < pick_val)) begin
                    // Lift the larger child into the hole and descend.
                    mem_wdata   = pick_val;
                    n_idx       = CW'(pick_idx);
                    mem_raddr_a = AW'(pick_child - 1'b1);
                    mem_raddr_b = AW'(pick_child);
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        fin_top = (mem_we && (mem_waddr == '0)) ? $signed(mem_wdata) : r_top;
        n_result.top_value   = (n_count != '0) ? fin_top : '0;
        n_result.entry_count = COUNT_W'(n_count);
        n_result.status      = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_idx <= n_idx;
        r_val <= n_val;
        if (n_strobe) begin
            r_result <= n_result;
        end
        // Mirror the root entry.
        if (mem_we && (mem_waddr == '0)) begin
            r_top <= mem_wdata;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `BMH_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `BMH_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, r_strobe, !busy, "result shown while busy")
    `BMH_ASSERT_NEXT(a_full_refuse, i_clk, i_rst_n, start && !busy && (i_request.op == OP_INSERT) && (r_count == CW'(CAPACITY)), r_strobe && (r_result.status == ST_FULL), "full insert not refused")
    `BMH_ASSERT_NEXT(a_empty_refuse, i_clk, i_rst_n, start && !busy && (i_request.op == OP_REPLACE) && (r_count == '0), r_strobe && (r_result.status == ST_EMPTY), "empty replace not refused")
    `BMH_ASSERT_SAME(a_ok_nonempty, i_clk, i_rst_n, r_strobe && (r_result.status == ST_OK), r_count != '0, "ok result with empty heap")

endmodule

>>> sv/bmh_ram.sv
// Heap storage: one write port, two registered read ports.
module bmh_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [bmh_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr_a,
    input  logic [AW-1:0]              i_raddr_b,
    output logic [bmh_pkg::DATA_W-1:0] o_rdata_a,
    output logic [bmh_pkg::DATA_W-1:0] o_rdata_b
);
    import bmh_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
